// ===== rtl/usbdev_pkg.sv =====
// shared types, codes and defaults of the usb device endpoint controller
package usbdev_pkg;

  localparam int NUM_ENDPOINTS_DEF = 6;
  localparam int FIFO_BYTES_DEF    = 64;

  typedef enum logic [2:0] {
    OP_CPU_READ  = 3'd0,
    OP_CPU_WRITE = 3'd1,
    OP_HOST_DATA = 3'd2,
    OP_SETUP     = 3'd3,
    OP_IN_READY  = 3'd4,
    OP_OUT_READY = 3'd5,
    OP_ATTACH    = 3'd6,
    OP_POLL      = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    KIND_READ     = 3'd0,
    KIND_TX       = 3'd1,
    KIND_TX_EMPTY = 3'd2,
    KIND_ACK      = 3'd3,
    KIND_EP_IRQ   = 3'd4,
    KIND_GEN_IRQ  = 3'd5
  } kind_t;

  localparam logic [7:0] ADDR_DEV_FLAGS = 8'hE1;
  localparam logic [7:0] ADDR_EP_FLAGS  = 8'hE8;
  localparam logic [7:0] ADDR_EP_SELECT = 8'hE9;
  localparam logic [7:0] ADDR_EP_CTRL   = 8'hEB;
  localparam logic [7:0] ADDR_EP_CFG0   = 8'hEC;
  localparam logic [7:0] ADDR_EP_CFG1   = 8'hED;
  localparam logic [7:0] ADDR_EP_IEN    = 8'hF0;
  localparam logic [7:0] ADDR_FIFO_DATA = 8'hF1;

  localparam int FLAG_TXIN  = 0;
  localparam int FLAG_RXOUT = 2;
  localparam int FLAG_SETUP = 3;

  localparam logic [7:0] DEV_ATTACHED = 8'h08;

  typedef struct packed {
    logic load;
    logic exec;
    logic push_imm;
    logic push_mem;
    logic tx_read;
    logic push_tx;
    logic clear_step;
  } cmd_t;

  typedef struct packed {
    logic needs_result;
    logic is_mem_read;
    logic is_tx;
    logic out_free;
    logic tx_last;
    logic clear_done;
  } sts_t;

endpackage

// ===== rtl/usbdev_req_if.sv =====
// request channel: one cpu access or host event per word
interface usbdev_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] reg_addr;
  logic [7:0] wdata;
  logic [2:0] ep_num;
  logic [5:0] fifo_pos;
  logic       global_int_on;

  modport source (output valid, opcode, reg_addr, wdata, ep_num, fifo_pos, global_int_on,
                  input ready);
  modport sink   (input valid, opcode, reg_addr, wdata, ep_num, fifo_pos, global_int_on,
                  output ready);
endinterface

// ===== rtl/usbdev_rsp_if.sv =====
// response channel: one result per word
interface usbdev_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] rdata;
  logic [2:0] out_ep;
  logic       last;

  modport source (output valid, kind, rdata, out_ep, last, input ready);
  modport sink   (input valid, kind, rdata, out_ep, last, output ready);
endinterface

// ===== rtl/usb_device_endpoint_controller.sv =====
// top level: usb device endpoint controller with cpu register port and host events
// each word is accepted in idle, then executed; fifo data reads add a memory output state
// a new word is taken only in idle, once the last one is done; a transmit reads and pushes
//   each fifo byte through the single read port, waiting while the output register is full
// reset: synchronous; registers clear at once, then a clearing pass zeroes the fifo memory
//   one byte per cycle (all NUM_ENDPOINTS * FIFO_BYTES bytes, 384 by default) before req.ready
module usb_device_endpoint_controller #(
  parameter int NUM_ENDPOINTS = usbdev_pkg::NUM_ENDPOINTS_DEF,
  parameter int FIFO_BYTES    = usbdev_pkg::FIFO_BYTES_DEF
) (
  input logic         clk,
  input logic         rst,
  usbdev_req_if.sink  req,
  usbdev_rsp_if.source rsp
);
  import usbdev_pkg::*;

  // command and status between the state machine and the datapath
  cmd_t cmd;
  sts_t sts;

  // controller: clearing pass, then one item at a time through execute,
  // with read and transmit states waiting on the output register
  usbdev_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: the output register lets a new word in while a result waits
  usbdev_dp #(
    .NUM_ENDPOINTS (NUM_ENDPOINTS),
    .FIFO_BYTES    (FIFO_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .opcode        (req.opcode),
    .reg_addr      (req.reg_addr),
    .wdata         (req.wdata),
    .ep_num        (req.ep_num),
    .fifo_pos      (req.fifo_pos),
    .global_int_on (req.global_int_on),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .out_kind      (rsp.kind),
    .out_rdata     (rsp.rdata),
    .out_ep        (rsp.out_ep),
    .out_last      (rsp.last)
  );

endmodule

// ===== rtl/usbdev_ctrl.sv =====
// control state machine: sequences clearing, execution, reads and transmit
module usbdev_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  usbdev_pkg::sts_t   sts,
  output usbdev_pkg::cmd_t   cmd
);
  import usbdev_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_EXEC   = 6'b000100,
    S_MEMOUT = 6'b001000,
    S_TXRD   = 6'b010000,
    S_TXOUT  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_mem_read) begin
          cmd.exec   = 1'b1;
          state_next = S_MEMOUT;
        end else if (sts.is_tx) begin
          cmd.exec   = 1'b1;
          state_next = S_TXRD;
        end else if (sts.needs_result) begin
          if (sts.out_free) begin
            cmd.exec     = 1'b1;
            cmd.push_imm = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_MEMOUT: begin
        if (sts.out_free) begin
          cmd.push_mem = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_TXRD: begin
        cmd.tx_read = 1'b1;
        state_next  = S_TXOUT;
      end
      S_TXOUT: begin
        if (sts.out_free) begin
          cmd.push_tx = 1'b1;
          state_next  = sts.tx_last ? S_IDLE : S_TXRD;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/usbdev_dp.sv =====
// datapath: endpoint registers, fifo memory, transmit counter and output register
module usbdev_dp #(
  parameter int NUM_ENDPOINTS = usbdev_pkg::NUM_ENDPOINTS_DEF,
  parameter int FIFO_BYTES    = usbdev_pkg::FIFO_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [2:0]       opcode,
  input  logic [7:0]       reg_addr,
  input  logic [7:0]       wdata,
  input  logic [2:0]       ep_num,
  input  logic [5:0]       fifo_pos,
  input  logic             global_int_on,
  input  usbdev_pkg::cmd_t cmd,
  output usbdev_pkg::sts_t sts,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_rdata,
  output logic [2:0]       out_ep,
  output logic             out_last
);
  import usbdev_pkg::*;

  localparam int EPW   = (NUM_ENDPOINTS > 1) ? $clog2(NUM_ENDPOINTS) : 1;
  localparam int OW    = $clog2(FIFO_BYTES);
  localparam int IW    = $clog2(FIFO_BYTES + 1);
  localparam int DEPTH = NUM_ENDPOINTS * FIFO_BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [IW-1:0] IDX_FULL  = IW'(FIFO_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // latched item
  op_t        op_q;
  logic [7:0] addr_q;
  logic [7:0] wdata_q;
  logic [2:0] cur_ep;
  logic [5:0] pos_q;
  logic       gie_q;

  // architectural state
  logic [2:0]    selected_ep;
  logic [7:0]    device_flags;
  logic [7:0]    ep_flags   [NUM_ENDPOINTS];
  logic [7:0]    ep_ien     [NUM_ENDPOINTS];
  logic [7:0]    ep_ctl     [NUM_ENDPOINTS];
  logic [7:0]    ep_cfg0    [NUM_ENDPOINTS];
  logic [7:0]    ep_cfg1    [NUM_ENDPOINTS];
  logic [IW-1:0] fifo_index [NUM_ENDPOINTS];

  logic [7:0]    mem [DEPTH];
  logic [7:0]    mem_q;

  logic [OW-1:0] tx_cnt;
  logic [IW-1:0] tx_len;
  logic [AW-1:0] clr_addr;

  // decode of the latched item
  logic [EPW-1:0] epi;
  logic           ep_ok;
  logic [IW-1:0]  cur_idx;
  logic           idx_full;
  logic           pos_ok;
  logic           flag_wr;
  logic           poll_hit;
  logic [AW-1:0]  ep_base;
  logic [7:0]     rd_val;
  logic           imm_has;
  kind_t          imm_kind;
  logic [7:0]     imm_data;
  logic [2:0]     imm_ep;

  assign epi      = cur_ep[EPW-1:0];
  assign ep_ok    = 32'(cur_ep) < NUM_ENDPOINTS;
  assign cur_idx  = fifo_index[epi];
  assign idx_full = (cur_idx == IDX_FULL);
  assign pos_ok   = 32'(pos_q) < FIFO_BYTES;
  assign ep_base  = AW'(32'(epi) * FIFO_BYTES);
  assign flag_wr  = (op_q == OP_CPU_WRITE) && (addr_q == ADDR_EP_FLAGS) && ep_ok;

  always_comb begin
    poll_hit = 1'b0;
    for (int i = 0; i < NUM_ENDPOINTS; i++) begin
      poll_hit = poll_hit | (|(ep_flags[i] & ep_ien[i]));
    end
  end

  always_comb begin
    rd_val = 8'h00;
    if (addr_q == ADDR_DEV_FLAGS) begin
      rd_val = device_flags;
    end else if (addr_q == ADDR_EP_SELECT) begin
      rd_val = {5'b0, selected_ep};
    end else if (ep_ok) begin
      case (addr_q)
        ADDR_EP_FLAGS: rd_val = ep_flags[epi];
        ADDR_EP_CTRL:  rd_val = ep_ctl[epi];
        ADDR_EP_CFG0:  rd_val = ep_cfg0[epi];
        ADDR_EP_CFG1:  rd_val = ep_cfg1[epi];
        ADDR_EP_IEN:   rd_val = ep_ien[epi];
        default:       rd_val = 8'h00;
      endcase
    end
  end

  // single result that an item produces right away
  always_comb begin
    imm_has  = 1'b0;
    imm_kind = KIND_READ;
    imm_data = 8'h00;
    imm_ep   = 3'd0;
    case (op_q)
      OP_CPU_READ: begin
        imm_has  = 1'b1;
        imm_data = rd_val;
      end
      OP_CPU_WRITE: begin
        if (flag_wr) begin
          if (!wdata_q[FLAG_SETUP]) begin
            imm_has  = 1'b1;
            imm_kind = KIND_ACK;
          end else if (!wdata_q[FLAG_TXIN] && cur_idx == '0) begin
            imm_has  = 1'b1;
            imm_kind = KIND_TX_EMPTY;
            imm_ep   = cur_ep;
          end
        end
      end
      OP_ATTACH: begin
        imm_has  = 1'b1;
        imm_kind = KIND_GEN_IRQ;
      end
      OP_POLL: begin
        if (gie_q && poll_hit) begin
          imm_has  = 1'b1;
          imm_kind = KIND_EP_IRQ;
        end
      end
      default: imm_has = 1'b0;
    endcase
  end

  assign sts.needs_result = imm_has;
  assign sts.is_mem_read  = (op_q == OP_CPU_READ) && (addr_q == ADDR_FIFO_DATA) && ep_ok &&
                            !idx_full;
  assign sts.is_tx        = flag_wr && wdata_q[FLAG_SETUP] && !wdata_q[FLAG_TXIN] &&
                            (cur_idx != '0);
  assign sts.out_free     = !out_valid || out_ready;
  assign sts.tx_last      = (IW'(tx_cnt) + IW'(1)) == tx_len;
  assign sts.clear_done   = (clr_addr == LAST_ADDR);

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= op_t'(opcode);
      addr_q  <= reg_addr;
      wdata_q <= wdata;
      pos_q   <= fifo_pos;
      gie_q   <= global_int_on;
      case (op_t'(opcode))
        OP_HOST_DATA, OP_IN_READY, OP_OUT_READY: cur_ep <= ep_num;
        OP_SETUP:                                cur_ep <= 3'd0;
        default:                                 cur_ep <= selected_ep;
      endcase
    end
  end

  // register file and fifo index updates
  always_ff @(posedge clk) begin
    if (rst) begin
      selected_ep  <= 3'd0;
      device_flags <= 8'h00;
      for (int i = 0; i < NUM_ENDPOINTS; i++) begin
        ep_flags[i]   <= 8'h00;
        ep_ien[i]     <= 8'h00;
        ep_ctl[i]     <= 8'h00;
        ep_cfg0[i]    <= 8'h00;
        ep_cfg1[i]    <= 8'h00;
        fifo_index[i] <= '0;
      end
    end else if (cmd.exec) begin
      case (op_q)
        OP_CPU_WRITE: begin
          if (addr_q == ADDR_DEV_FLAGS) begin
            device_flags <= wdata_q;
          end else if (addr_q == ADDR_EP_SELECT) begin
            selected_ep <= wdata_q[2:0];
          end else if (ep_ok) begin
            case (addr_q)
              ADDR_EP_CTRL: ep_ctl[epi]  <= wdata_q;
              ADDR_EP_CFG0: ep_cfg0[epi] <= wdata_q;
              ADDR_EP_CFG1: ep_cfg1[epi] <= wdata_q;
              ADDR_EP_IEN:  ep_ien[epi]  <= wdata_q;
              ADDR_FIFO_DATA: begin
                if (!idx_full) fifo_index[epi] <= cur_idx + IW'(1);
              end
              ADDR_EP_FLAGS: begin
                ep_flags[epi] <= ep_flags[epi] & wdata_q;
                if (!wdata_q[FLAG_SETUP] || !wdata_q[FLAG_TXIN]) fifo_index[epi] <= '0;
              end
              default: ;
            endcase
          end
        end
        OP_CPU_READ: begin
          if (addr_q == ADDR_FIFO_DATA && ep_ok && !idx_full) begin
            fifo_index[epi] <= cur_idx + IW'(1);
          end
        end
        OP_SETUP: begin
          fifo_index[0]            <= '0;
          ep_flags[0][FLAG_SETUP] <= 1'b1;
        end
        OP_IN_READY: begin
          if (ep_ok) ep_flags[epi][FLAG_TXIN] <= 1'b1;
        end
        OP_OUT_READY: begin
          if (ep_ok) ep_flags[epi][FLAG_RXOUT] <= 1'b1;
        end
        OP_ATTACH: device_flags <= DEV_ATTACHED;
        default: ;
      endcase
    end
  end

  // transmit length and byte counter
  always_ff @(posedge clk) begin
    if (cmd.exec && sts.is_tx) begin
      tx_len <= cur_idx;
      tx_cnt <= '0;
    end else if (cmd.push_tx) begin
      tx_cnt <= tx_cnt + OW'(1);
    end
  end

  // clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step && !sts.clear_done) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // fifo memory, one write and one read port
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_addr;
    mem_wd = 8'h00;
    if (cmd.clear_step) begin
      mem_we = 1'b1;
    end else if (cmd.exec && op_q == OP_CPU_WRITE && addr_q == ADDR_FIFO_DATA && ep_ok &&
                 !idx_full) begin
      mem_we = 1'b1;
      mem_wa = ep_base + AW'(cur_idx[OW-1:0]);
      mem_wd = wdata_q;
    end else if (cmd.exec && op_q == OP_HOST_DATA && ep_ok && pos_ok) begin
      mem_we = 1'b1;
      mem_wa = ep_base + AW'(pos_q);
      mem_wd = wdata_q;
    end
  end

  always_comb begin
    mem_re = 1'b0;
    mem_ra = ep_base + AW'(tx_cnt);
    if (cmd.tx_read) begin
      mem_re = 1'b1;
    end else if (cmd.exec && sts.is_mem_read) begin
      mem_re = 1'b1;
      mem_ra = ep_base + AW'(cur_idx[OW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_q <= mem[mem_ra];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push_imm || cmd.push_mem || cmd.push_tx) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_imm) begin
      out_kind  <= imm_kind;
      out_rdata <= imm_data;
      out_ep    <= imm_ep;
      out_last  <= 1'b1;
    end else if (cmd.push_mem) begin
      out_kind  <= KIND_READ;
      out_rdata <= mem_q;
      out_ep    <= 3'd0;
      out_last  <= 1'b1;
    end else if (cmd.push_tx) begin
      out_kind  <= KIND_TX;
      out_rdata <= mem_q;
      out_ep    <= cur_ep;
      out_last  <= sts.tx_last;
    end
  end

endmodule
